>>> design/bir_pkg.sv
// Shared constants and types of the bilinear image resizer.
package bir_pkg;

	localparam int STORE_BYTES = 262144;
	localparam int MAX_SIDE    = 4096;
	localparam int ADDR_W      = $clog2(STORE_BYTES);

	localparam logic [31:0] STORE_LIMIT = 32'(STORE_BYTES);
	localparam logic [12:0] SIDE_MAX    = 13'(MAX_SIDE);

	// configuration register indexes
	localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [2:0] REG_CHANNELS   = 3'd2;
	localparam logic [2:0] REG_DST_WIDTH  = 3'd3;
	localparam logic [2:0] REG_DST_HEIGHT = 3'd4;

	// clamped sizes and Q13.16 ratios
	typedef struct packed {
		logic [12:0] sw;
		logic [12:0] sh;
		logic [2:0]  ch;
		logic [12:0] dw;
		logic [12:0] dh;
		logic [28:0] xr;
		logic [28:0] yr;
	} geom_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] pixel;
		logic       err;
	} res_t;

endpackage

>>> design/bir_div.sv
// Restoring divider, one quotient bit per cycle, for the scale ratios.
module bir_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [28:0] dividend,
	input  logic [12:0] divisor,
	output logic        done,
	output logic [28:0] quotient
);
	import bir_pkg::*;

	localparam int DIV_STEPS = 29;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [12:0] rem_q;
	logic [28:0] dq_q;
	logic [12:0] dvs_q;
	logic [13:0] trial;
	logic        fits;

	assign trial = {rem_q, dq_q[28]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// hold the divisor for the whole division
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 13'(trial - {1'b0, dvs_q}) : trial[12:0];
			dq_q  <= {dq_q[27:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

>>> design/bir_store.sv
// Source byte store: single port, registered read.
module bir_store (
	input  logic                       clk,
	input  logic                       we,
	input  logic [bir_pkg::ADDR_W-1:0] addr,
	input  logic [7:0]                 wdata,
	output logic [7:0]                 rdata
);
	import bir_pkg::*;

	logic [7:0] mem [STORE_BYTES];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/bir_core.sv
// Query sequencer: source position, addresses, four store reads and weighting.
module bir_core (
	input  logic           clk,
	input  logic           arst_n,
	input  bir_pkg::geom_t geom,
	input  logic           in_take,
	input  logic           mode,
	input  logic [17:0]    load_index,
	input  logic [7:0]     load_value,
	input  logic [11:0]    out_x,
	input  logic [11:0]    out_y,
	input  logic [1:0]     out_channel,
	output logic           busy,
	output bir_pkg::res_t  res,
	input  logic           res_take
);
	import bir_pkg::*;

	localparam logic [3:0] Q_IDLE  = 4'd0;
	localparam logic [3:0] Q_MAP   = 4'd1;
	localparam logic [3:0] Q_POS   = 4'd2;
	localparam logic [3:0] Q_ROW   = 4'd3;
	localparam logic [3:0] Q_ADDR  = 4'd4;
	localparam logic [3:0] Q_CHK   = 4'd5;
	localparam logic [3:0] Q_READ  = 4'd6;
	localparam logic [3:0] Q_DRAIN = 4'd7;
	localparam logic [3:0] Q_DONE  = 4'd8;

	logic [3:0]  state_q;
	logic [1:0]  cnt_q;
	logic [11:0] ox_q, oy_q;
	logic [1:0]  oc_q;
	logic        qerr_q, err_q;
	logic [27:0] sx_q, sy_q;
	logic [11:0] x1_q, y1_q;
	logic        dx_q, dy_q;
	logic [15:0] fx_q, fy_q;
	logic [23:0] pix_q;
	logic [14:0] strd_q;
	logic [25:0] a11_q, a21_q, a12_q, a22_q;
	logic [2:0]  stepx_q;
	logic [14:0] stepy_q;
	logic [32:0] w_s1;
	logic        v_s1;
	logic [39:0] prod_s2;
	logic        v_s2;
	logic [39:0] acc_q;

	logic [40:0] sx_full, sy_full;
	logic [12:0] swm1, shm1, x1c, y1c;
	logic [24:0] pix_full;
	logic [15:0] strd_full;
	logic [26:0] a11_full;
	logic [25:0] a21, a12, a22;
	logic        chk_err;
	logic [16:0] gx, gy, wx, wy;
	logic [33:0] w_full;
	logic [40:0] prod_full;
	logic [25:0] rd_sel;
	logic [31:0] load_idx32;
	logic [ADDR_W-1:0] mem_addr;
	logic        mem_we;
	logic [7:0]  rdata;

	assign sx_full = ox_q * geom.xr;
	assign sy_full = oy_q * geom.yr;

	assign swm1 = geom.sw - 13'd1;
	assign shm1 = geom.sh - 13'd1;
	assign x1c  = ({1'b0, sx_q[27:16]} > swm1) ? swm1 : {1'b0, sx_q[27:16]};
	assign y1c  = ({1'b0, sy_q[27:16]} > shm1) ? shm1 : {1'b0, sy_q[27:16]};

	assign pix_full  = y1_q * geom.sw + 25'(x1_q);
	assign strd_full = geom.sw * geom.ch;
	assign a11_full  = pix_q * geom.ch + 27'(oc_q);

	// the lower right neighbor has the highest address of the four
	assign a21     = a11_q + 26'(stepx_q);
	assign a12     = a11_q + 26'(stepy_q);
	assign a22     = a12 + 26'(stepx_q);
	assign chk_err = qerr_q || ({6'd0, a22} >= STORE_LIMIT);

	assign gx = 17'h10000 - 17'(fx_q);
	assign gy = 17'h10000 - 17'(fy_q);
	assign wx = cnt_q[0] ? 17'(fx_q) : gx;
	assign wy = cnt_q[1] ? 17'(fy_q) : gy;
	assign w_full = wx * wy;

	assign prod_full = rdata * w_s1;

	always_comb begin
		unique case (cnt_q)
			2'd0: rd_sel = a11_q;
			2'd1: rd_sel = a21_q;
			2'd2: rd_sel = a12_q;
			2'd3: rd_sel = a22_q;
			default: rd_sel = a11_q;
		endcase
	end

	assign load_idx32 = 32'(load_index);
	assign mem_we     = in_take && !mode && (load_idx32 < STORE_LIMIT);
	assign mem_addr   = (state_q == Q_READ) ? rd_sel[ADDR_W-1:0] : load_idx32[ADDR_W-1:0];

	bir_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (load_value),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= Q_IDLE;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			v_s1 <= (state_q == Q_READ);
			v_s2 <= v_s1;
			unique case (state_q)
				Q_IDLE: begin
					if (in_take && mode) begin
						state_q <= Q_MAP;
					end
				end
				Q_MAP:  state_q <= Q_POS;
				Q_POS:  state_q <= Q_ROW;
				Q_ROW:  state_q <= Q_ADDR;
				Q_ADDR: state_q <= Q_CHK;
				Q_CHK: begin
					cnt_q   <= '0;
					state_q <= chk_err ? Q_DONE : Q_READ;
				end
				Q_READ: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= Q_DRAIN;
					end
				end
				Q_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= Q_DONE;
					end
				end
				Q_DONE: begin
					if (res_take) begin
						state_q <= Q_IDLE;
					end
				end
				default: state_q <= Q_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == Q_IDLE) begin
			ox_q   <= out_x;
			oy_q   <= out_y;
			oc_q   <= out_channel;
			qerr_q <= ({1'b0, out_x} >= geom.dw) || ({1'b0, out_y} >= geom.dh)
				|| ({1'b0, out_channel} >= geom.ch);
		end
		if (state_q == Q_MAP) begin
			sx_q <= sx_full[27:0];
			sy_q <= sy_full[27:0];
		end
		if (state_q == Q_POS) begin
			x1_q <= x1c[11:0];
			y1_q <= y1c[11:0];
			dx_q <= (14'(x1c) + 14'd1) < 14'(geom.sw);
			dy_q <= (14'(y1c) + 14'd1) < 14'(geom.sh);
			fx_q <= sx_q[15:0];
			fy_q <= sy_q[15:0];
		end
		if (state_q == Q_ROW) begin
			pix_q  <= pix_full[23:0];
			strd_q <= strd_full[14:0];
		end
		if (state_q == Q_ADDR) begin
			a11_q   <= a11_full[25:0];
			stepx_q <= dx_q ? geom.ch : 3'd0;
			stepy_q <= dy_q ? strd_q : 15'd0;
		end
		if (state_q == Q_CHK) begin
			a21_q <= a21;
			a12_q <= a12;
			a22_q <= a22;
			err_q <= chk_err;
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + prod_s2;
		end
		w_s1    <= w_full[32:0];
		prod_s2 <= prod_full[39:0];
	end

	assign busy      = (state_q != Q_IDLE);
	assign res.valid = (state_q == Q_DONE);
	assign res.pixel = err_q ? 8'd0 : acc_q[39:32];
	assign res.err   = err_q;

endmodule

>>> design/bilinear_image_resize.sv
// Bilinear image resizer top level: configuration, ratio unit, result register.
// Loads may follow back to back while the input does not stall.
// A query fills the result register after the map, position, row, address and check states
// and four reads through the single store port; a range error skips the reads. No new query is taken until then.
// After reset and after each configuration write the input stalls
// while the divider forms both Q13.16 ratios, one after the other.
// Reset sets every size register to 1; the source store holds no defined contents.
module bilinear_image_resize (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [17:0] load_index,
	input  logic [7:0]  load_value,
	input  logic [11:0] out_x,
	input  logic [11:0] out_y,
	input  logic [1:0]  out_channel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  pixel_out,
	output logic        range_error
);
	import bir_pkg::*;

	localparam logic [1:0] RS_IDLE = 2'd0;
	localparam logic [1:0] RS_X    = 2'd1;
	localparam logic [1:0] RS_Y    = 2'd2;

	logic [12:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
	logic [2:0]  channels_q;
	logic [28:0] xr_q, yr_q;
	logic [1:0]  rs_q;
	logic        dirty_q;
	logic        out_valid_q, err_q;
	logic [7:0]  pixel_q;

	geom_t       geom;
	res_t        res;
	logic        core_busy, in_take, res_take, ratio_ok;
	logic        div_start, div_done;
	logic [28:0] div_dividend, div_quotient;
	logic [12:0] div_divisor;

	function automatic logic [12:0] clamp_side(input logic [12:0] v);
		if (v == 13'd0) return 13'd1;
		if (v > SIDE_MAX) return SIDE_MAX;
		return v;
	endfunction

	assign geom.sw = clamp_side(src_width_q);
	assign geom.sh = clamp_side(src_height_q);
	assign geom.dw = clamp_side(dst_width_q);
	assign geom.dh = clamp_side(dst_height_q);
	assign geom.ch = (channels_q == 3'd0) ? 3'd1 : ((channels_q > 3'd4) ? 3'd4 : channels_q);
	assign geom.xr = xr_q;
	assign geom.yr = yr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= 13'd1;
			src_height_q <= 13'd1;
			channels_q   <= 3'd1;
			dst_width_q  <= 13'd1;
			dst_height_q <= 13'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SRC_WIDTH:  src_width_q  <= cfg_data;
				REG_SRC_HEIGHT: src_height_q <= cfg_data;
				REG_CHANNELS:   channels_q   <= cfg_data[2:0];
				REG_DST_WIDTH:  dst_width_q  <= cfg_data;
				REG_DST_HEIGHT: dst_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// recompute both ratios whenever the sizes may have changed
	assign div_start    = ((rs_q == RS_IDLE) && dirty_q) || ((rs_q == RS_X) && div_done);
	assign div_dividend = (rs_q == RS_X) ? {geom.sh, 16'd0} : {geom.sw, 16'd0};
	assign div_divisor  = (rs_q == RS_X) ? geom.dh : geom.dw;

	bir_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q    <= RS_IDLE;
			dirty_q <= 1'b1;
		end else begin
			if (cfg_write) begin
				dirty_q <= 1'b1;
			end else if ((rs_q == RS_IDLE) && dirty_q) begin
				dirty_q <= 1'b0;
			end
			unique case (rs_q)
				RS_IDLE: begin
					if (dirty_q) begin
						rs_q <= RS_X;
					end
				end
				RS_X: begin
					if (div_done) begin
						rs_q <= RS_Y;
					end
				end
				RS_Y: begin
					if (div_done) begin
						rs_q <= RS_IDLE;
					end
				end
				default: rs_q <= RS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((rs_q == RS_X) && div_done) begin
			xr_q <= div_quotient;
		end
		if ((rs_q == RS_Y) && div_done) begin
			yr_q <= div_quotient;
		end
	end

	assign ratio_ok = (rs_q == RS_IDLE) && !dirty_q;
	assign in_stall = core_busy || !ratio_ok;
	assign in_take  = in_valid && !in_stall;

	bir_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.geom        (geom),
		.in_take     (in_take),
		.mode        (mode),
		.load_index  (load_index),
		.load_value  (load_value),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_channel (out_channel),
		.busy        (core_busy),
		.res         (res),
		.res_take    (res_take)
	);

	// the core holds its result until the output register is empty or not stalled
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res.valid) begin
			pixel_q <= res.pixel;
			err_q   <= res.err;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_out   = pixel_q;
	assign range_error = err_q;

endmodule

>>> design/bir_checker.sv
// Port-level checks of the bilinear image resizer, bound to the top level.
module bir_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_write,
	input logic       in_valid,
	input logic       in_stall,
	input logic       mode,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] pixel_out,
	input logic       range_error
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(range_error))
		else $error("stalled result changed");

	// a rejected query carries a zero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> pixel_out == 8'd0)
		else $error("range error with nonzero pixel");

	// a query occupies the block after acceptance
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode |=> in_stall)
		else $error("query accepted without busy");

	// a configuration write starts a ratio update that blocks input
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |=> in_stall)
		else $error("input open during ratio update");

	// a new result appears only after the block was busy
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a busy query");

endmodule

bind bilinear_image_resize bir_checker u_bir_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_write   (cfg_write),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.mode        (mode),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pixel_out   (pixel_out),
	.range_error (range_error)
);
